[rtl/core/pps_pkg.sv]
// pps_pkg: shared constants, codes and word types of the polygon plane split unit.
// Used by every module under rtl/core; depends on nothing.
package pps_pkg;

  localparam int MAX_VERTS  = 16;
  localparam int IDX_W      = $clog2(MAX_VERTS);
  localparam int CNT_W      = $clog2(MAX_VERTS + 1);
  localparam int COORD_W    = 24;
  localparam int NORM_W     = 18;
  localparam int EPS_W      = 8;
  localparam int DIST_W     = 32;
  localparam int PROD_W     = COORD_W + NORM_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FRAC_SH    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int BIT_W      = $clog2(DIFF_W);
  localparam int QUO_W      = DIFF_W + 1;
  localparam int REM_W      = DIST_W + 2;
  localparam int RES_W      = QUO_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic signed [NORM_W-1:0] UNIT_NORMAL = NORM_W'(65536);
  localparam logic signed [SUM_W-1:0]  ROUND_HALF  = SUM_W'(32768);
  localparam logic signed [COORD_W-1:0] COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_DIST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ON_EPSILON = 3'd4;

  // Polygon class codes on the result word
  localparam logic [1:0] PCLS_SPLIT = 2'd0;
  localparam logic [1:0] PCLS_FRONT = 2'd1;
  localparam logic [1:0] PCLS_BACK  = 2'd2;

  typedef enum logic [1:0] {
    CLS_FRONT = 2'd0,
    CLS_BACK  = 2'd1,
    CLS_ON    = 2'd2
  } vcls_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nz;
    logic signed [COORD_W-1:0] pd;
    logic [EPS_W-1:0]          eps;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic signed [COORD_W-1:0] vert_z;
    logic                      last_vertex;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      out_side;
    logic                      split_point;
    logic [1:0]                polygon_class;
    logic                      overflow;
    logic                      run_end;
  } out_word_t;

  // Classified vertex passed from front to back
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [DIST_W-1:0]  d;
    vcls_t                     cls;
    logic                      keep;
    logic                      last;
    logic                      drop;
  } vrec_t;

endpackage

[rtl/core/polygon_plane_split_unit.sv]
// polygon_plane_split_unit: top level of the polygon plane split unit.
// Depends on pps_pkg, pps_front, pps_queue and pps_back.
//
// Vertices are pushed one word at a time; the word with last_vertex set ends
// the polygon. The front part takes one vertex at a time, holding in_full
// until it is pushed (capture, three parallel multiplies, sum and round,
// push), and passes it through a 4-entry queue, so it keeps loading while the
// back part is still emitting the previous polygon. The back part buffers up
// to 16 vertices, then walks them, per vertex of a split polygon with two
// buffer reads, decide, hand over; split points come from the radix-2 divider
// that is shared by the three coordinates. Results leave through a one-word
// output register; a polygon's run_end word is released once the walk of its
// run is complete.
// Configuration is written through cfg_valid/cfg_index/cfg_data and must only
// change while the unit is idle.
module polygon_plane_split_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  pps_pkg::in_word_t               in_data,
  output logic                            out_empty,
  input  logic                            out_pop,
  output pps_pkg::out_word_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pps_pkg::cfg_t   cfg_r;
  logic            q_push, q_full, q_pop, q_empty;
  pps_pkg::vrec_t  q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nx  <= '0;
      cfg_r.ny  <= '0;
      cfg_r.nz  <= pps_pkg::UNIT_NORMAL;
      cfg_r.pd  <= '0;
      cfg_r.eps <= pps_pkg::EPS_W'(3);
    end else if (cfg_valid) begin
      case (cfg_index)
        pps_pkg::REG_NORMAL_X:   cfg_r.nx  <= cfg_data[pps_pkg::NORM_W-1:0];
        pps_pkg::REG_NORMAL_Y:   cfg_r.ny  <= cfg_data[pps_pkg::NORM_W-1:0];
        pps_pkg::REG_NORMAL_Z:   cfg_r.nz  <= cfg_data[pps_pkg::NORM_W-1:0];
        pps_pkg::REG_PLANE_DIST: cfg_r.pd  <= cfg_data[pps_pkg::COORD_W-1:0];
        pps_pkg::REG_ON_EPSILON: cfg_r.eps <= cfg_data[pps_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  pps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_data  (q_wdata)
  );

  pps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  pps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

[rtl/core/pps_front.sv]
// pps_front: accepts vertex words, computes the plane distance and class.
// Depends on pps_pkg; feeds classified records into pps_queue.
module pps_front (
  input  logic                clk,
  input  logic                rst_n,
  input  pps_pkg::cfg_t       cfg,
  input  logic                in_push,
  output logic                in_full,
  input  pps_pkg::in_word_t   in_data,
  output logic                q_push,
  input  logic                q_full,
  output pps_pkg::vrec_t      q_data
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM, F_PUSH} fst_t;

  fst_t                                state_r;
  logic [pps_pkg::CNT_W-1:0]           cnt_r;
  logic                                drop_r;
  logic                                keep_r;
  logic                                last_r;
  logic signed [pps_pkg::COORD_W-1:0]  x_r, y_r, z_r;
  logic signed [pps_pkg::PROD_W-1:0]   px_r, py_r, pz_r;
  logic signed [pps_pkg::DIST_W-1:0]   d_r;
  logic signed [pps_pkg::SUM_W-1:0]    sum_c;
  logic signed [pps_pkg::DIST_W-1:0]   eps_c;
  pps_pkg::vcls_t                      cls_c;
  logic                                full_c;

  assign in_full = (state_r != F_IDLE);
  assign full_c  = (cnt_r == pps_pkg::CNT_W'(pps_pkg::MAX_VERTS));

  // Round the dot product to a signed 28-bit integer (Q28.0)
  assign sum_c = pps_pkg::SUM_W'(px_r) + pps_pkg::SUM_W'(py_r) + pps_pkg::SUM_W'(pz_r)
               + pps_pkg::ROUND_HALF;

  // Class against the on-plane band
  assign eps_c = $signed({{(pps_pkg::DIST_W-pps_pkg::EPS_W){1'b0}}, cfg.eps});
  always_comb begin
    if (d_r > eps_c) begin
      cls_c = pps_pkg::CLS_FRONT;
    end else if (d_r < -eps_c) begin
      cls_c = pps_pkg::CLS_BACK;
    end else begin
      cls_c = pps_pkg::CLS_ON;
    end
  end

  assign q_push = (state_r == F_PUSH) && !q_full;
  always_comb begin
    q_data      = '0;
    q_data.x    = x_r;
    q_data.y    = y_r;
    q_data.z    = z_r;
    q_data.d    = d_r;
    q_data.cls  = cls_c;
    q_data.keep = keep_r;
    q_data.last = last_r;
    q_data.drop = drop_r;
  end

  // Sequence one vertex: capture, multiply, sum, push; past the buffer depth, drop it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      keep_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_push) begin
            x_r    <= in_data.vert_x;
            y_r    <= in_data.vert_y;
            z_r    <= in_data.vert_z;
            last_r <= in_data.last_vertex;
            if (full_c) begin
              drop_r <= 1'b1;
              keep_r <= 1'b0;
              if (in_data.last_vertex) begin
                state_r <= F_PUSH;
              end
            end else begin
              keep_r  <= 1'b1;
              state_r <= F_MUL;
            end
          end
        end
        F_MUL: begin
          px_r    <= x_r * cfg.nx;
          py_r    <= y_r * cfg.ny;
          pz_r    <= z_r * cfg.nz;
          state_r <= F_SUM;
        end
        F_SUM: begin
          d_r <= pps_pkg::DIST_W'($signed(sum_c[pps_pkg::SUM_W-1:pps_pkg::FRAC_SH]))
               - pps_pkg::DIST_W'(cfg.pd);
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            if (last_r) begin
              cnt_r  <= '0;
              drop_r <= 1'b0;
            end else if (keep_r) begin
              cnt_r <= cnt_r + 1'b1;
            end
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/pps_queue.sv]
// pps_queue: short record queue between the front and back parts.
// Depends on pps_pkg for the record type and depth.
module pps_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pps_pkg::vrec_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output pps_pkg::vrec_t  pop_data
);

  pps_pkg::vrec_t              slot_r [pps_pkg::QDEPTH];
  logic [pps_pkg::QPTR_W-1:0]  wr_r, rd_r;
  logic [pps_pkg::QPTR_W:0]    cnt_r;
  logic                        do_push, do_pop;

  assign full     = (cnt_r == (pps_pkg::QPTR_W+1)'(pps_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/pps_back.sv]
// pps_back: buffers one polygon, walks it and emits front and back runs,
// interpolating split points with a radix-2 shared divider. Depends on pps_pkg.
module pps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pps_pkg::cfg_t        cfg,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  pps_pkg::vrec_t       q_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output pps_pkg::out_word_t   out_data
);

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_RDI, S_RDJ, S_GOTJ, S_DEC, S_PUTV,
    S_DSET, S_DIT, S_DFIN, S_PUTS, S_NEXT, S_FLUSH
  } bst_t;

  bst_t                                state_r;
  pps_pkg::vrec_t                      mem [pps_pkg::MAX_VERTS];
  pps_pkg::vrec_t                      rd_q_r;
  logic [pps_pkg::IDX_W-1:0]           rd_addr;
  logic                                wr_en;

  logic [pps_pkg::CNT_W-1:0]           cnt_r;
  logic                                seen_f_r, seen_b_r, drop_r;
  logic                                whole_r, side_r;
  logic [1:0]                          pcls_r;
  logic [pps_pkg::IDX_W-1:0]           idx_r, jdx_c;
  logic                                at_last_c;
  pps_pkg::vrec_t                      cur_r, nxt_r;
  logic                                need_sp_r;
  logic [1:0]                          crd_r;
  logic [pps_pkg::BIT_W-1:0]           bit_r;
  logic [pps_pkg::DIFF_W-1:0]          dm_r;
  logic                                neg_r;
  logic [pps_pkg::REM_W-1:0]           d1m_r, den_r, rem_r;
  logic [pps_pkg::QUO_W-1:0]           q_r;
  logic signed [pps_pkg::COORD_W-1:0]  spx_r, spy_r, spz_r;
  pps_pkg::out_word_t                  pend_r, out_r, cand_c, fin_c;
  logic                                pend_v_r, out_v_r;
  logic                                out_free, put_ok, load_out_c;

  logic signed [pps_pkg::COORD_W-1:0]  a_sel, b_sel;
  logic signed [pps_pkg::NORM_W-1:0]   n_sel;
  logic signed [pps_pkg::DIFF_W-1:0]   diff_c;
  logic [pps_pkg::DIST_W-1:0]          d1m_c, d2m_c;
  logic [pps_pkg::REM_W-1:0]           t_c, den2_c;
  logic [pps_pkg::QUO_W-1:0]           qf_c;
  logic signed [pps_pkg::RES_W-1:0]    val_c;
  logic signed [pps_pkg::COORD_W-1:0]  coord_c;
  logic                                emit_c, ns_c;
  pps_pkg::vcls_t                      side_cls;

  assign out_empty = !out_v_r;
  assign out_data  = out_r;
  assign out_free  = !out_v_r || out_pop;
  assign put_ok    = !pend_v_r || out_free;
  assign q_pop     = (state_r == S_LOAD) && !q_empty;

  assign at_last_c = ((pps_pkg::CNT_W'(idx_r) + 1'b1) == cnt_r);
  assign jdx_c     = at_last_c ? '0 : idx_r + 1'b1;
  assign rd_addr   = (state_r == S_RDJ) ? jdx_c : idx_r;
  assign wr_en     = q_pop && q_data.keep;

  // Polygon buffer, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[pps_pkg::IDX_W-1:0]] <= q_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Emit and split decisions for the current vertex
  assign side_cls = side_r ? pps_pkg::CLS_BACK : pps_pkg::CLS_FRONT;
  assign emit_c   = (cur_r.cls == pps_pkg::CLS_ON) || (cur_r.cls == side_cls);
  assign ns_c     = (cur_r.cls != pps_pkg::CLS_ON) && (nxt_r.cls != pps_pkg::CLS_ON)
                 && (nxt_r.cls != cur_r.cls);

  // Select coordinate and normal component being interpolated
  always_comb begin
    case (crd_r)
      2'd0: begin
        a_sel = cur_r.x;
        b_sel = nxt_r.x;
        n_sel = cfg.nx;
      end
      2'd1: begin
        a_sel = cur_r.y;
        b_sel = nxt_r.y;
        n_sel = cfg.ny;
      end
      default: begin
        a_sel = cur_r.z;
        b_sel = nxt_r.z;
        n_sel = cfg.nz;
      end
    endcase
  end

  assign diff_c = pps_pkg::DIFF_W'(b_sel) - pps_pkg::DIFF_W'(a_sel);
  assign d1m_c  = cur_r.d[pps_pkg::DIST_W-1] ? pps_pkg::DIST_W'(-cur_r.d)
                                               : pps_pkg::DIST_W'(cur_r.d);
  assign d2m_c  = nxt_r.d[pps_pkg::DIST_W-1] ? pps_pkg::DIST_W'(-nxt_r.d)
                                               : pps_pkg::DIST_W'(nxt_r.d);

  // One radix-2 step: the partial remainder gains at most two divisors
  assign t_c    = {rem_r[pps_pkg::REM_W-2:0], 1'b0} + (dm_r[pps_pkg::DIFF_W-1] ? d1m_r : '0);
  assign den2_c = {den_r[pps_pkg::REM_W-2:0], 1'b0};

  // Round half away from zero, apply sign, saturate; a unit normal component gives the plane distance
  assign qf_c  = q_r + pps_pkg::QUO_W'((rem_r + (den_r >> 1)) >= den_r);
  assign val_c = neg_r ? pps_pkg::RES_W'(a_sel) - $signed({1'b0, qf_c})
                       : pps_pkg::RES_W'(a_sel) + $signed({1'b0, qf_c});
  always_comb begin
    if (n_sel == pps_pkg::UNIT_NORMAL) begin
      coord_c = cfg.pd;
    end else if (n_sel == -pps_pkg::UNIT_NORMAL) begin
      coord_c = (cfg.pd == pps_pkg::COORD_MIN) ? pps_pkg::COORD_MAX : -cfg.pd;
    end else if (val_c > pps_pkg::RES_W'(pps_pkg::COORD_MAX)) begin
      coord_c = pps_pkg::COORD_MAX;
    end else if (val_c < pps_pkg::RES_W'(pps_pkg::COORD_MIN)) begin
      coord_c = pps_pkg::COORD_MIN;
    end else begin
      coord_c = pps_pkg::COORD_W'(val_c);
    end
  end

  // Candidate result word
  always_comb begin
    cand_c               = '0;
    cand_c.out_side      = side_r;
    cand_c.polygon_class = pcls_r;
    cand_c.overflow      = drop_r;
    if (state_r == S_PUTS) begin
      cand_c.out_x       = spx_r;
      cand_c.out_y       = spy_r;
      cand_c.out_z       = spz_r;
      cand_c.split_point = 1'b1;
    end else begin
      cand_c.out_x       = cur_r.x;
      cand_c.out_y       = cur_r.y;
      cand_c.out_z       = cur_r.z;
    end
  end

  // Mark the held word as the end of its run
  always_comb begin
    fin_c         = pend_r;
    fin_c.run_end = 1'b1;
  end

  assign load_out_c = pend_v_r && out_free
                   && (state_r == S_PUTV || state_r == S_PUTS || state_r == S_FLUSH);

  // Hand the held word to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load_out_c) begin
      out_r   <= (state_r == S_FLUSH) ? fin_c : pend_r;
      out_v_r <= 1'b1;
    end else if (out_pop) begin
      out_v_r <= 1'b0;
    end
  end

  // Load, walk, interpolate, and hold one result back to mark run ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      cnt_r    <= '0;
      seen_f_r <= 1'b0;
      seen_b_r <= 1'b0;
      drop_r   <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (!q_empty) begin
            if (q_data.keep) begin
              cnt_r <= cnt_r + 1'b1;
              if (q_data.cls == pps_pkg::CLS_FRONT) begin
                seen_f_r <= 1'b1;
              end
              if (q_data.cls == pps_pkg::CLS_BACK) begin
                seen_b_r <= 1'b1;
              end
            end
            if (q_data.last) begin
              drop_r  <= q_data.drop;
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          idx_r <= '0;
          if (!seen_f_r) begin
            whole_r <= 1'b1;
            side_r  <= 1'b1;
            pcls_r  <= pps_pkg::PCLS_BACK;
          end else if (!seen_b_r) begin
            whole_r <= 1'b1;
            side_r  <= 1'b0;
            pcls_r  <= pps_pkg::PCLS_FRONT;
          end else begin
            whole_r <= 1'b0;
            side_r  <= 1'b0;
            pcls_r  <= pps_pkg::PCLS_SPLIT;
          end
          state_r <= S_RDI;
        end
        S_RDI: state_r <= S_RDJ;
        S_RDJ: begin
          cur_r     <= rd_q_r;
          need_sp_r <= 1'b0;
          state_r   <= whole_r ? S_PUTV : S_GOTJ;
        end
        S_GOTJ: begin
          nxt_r   <= rd_q_r;
          state_r <= S_DEC;
        end
        S_DEC: begin
          need_sp_r <= ns_c;
          crd_r     <= 2'd0;
          if (emit_c) begin
            state_r <= S_PUTV;
          end else if (ns_c) begin
            state_r <= S_DSET;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_PUTV, S_PUTS: begin
          if (put_ok) begin
            pend_r   <= cand_c;
            pend_v_r <= 1'b1;
            crd_r    <= 2'd0;
            state_r  <= (state_r == S_PUTV && need_sp_r) ? S_DSET : S_NEXT;
          end
        end
        S_DSET: begin
          neg_r   <= diff_c[pps_pkg::DIFF_W-1];
          dm_r    <= diff_c[pps_pkg::DIFF_W-1] ? pps_pkg::DIFF_W'(-diff_c)
                                                 : pps_pkg::DIFF_W'(diff_c);
          d1m_r   <= pps_pkg::REM_W'(d1m_c);
          den_r   <= pps_pkg::REM_W'(d1m_c) + pps_pkg::REM_W'(d2m_c);
          rem_r   <= '0;
          q_r     <= '0;
          bit_r   <= pps_pkg::BIT_W'(pps_pkg::DIFF_W - 1);
          state_r <= S_DIT;
        end
        S_DIT: begin
          if (t_c >= den2_c) begin
            rem_r <= t_c - den2_c;
            q_r   <= {q_r[pps_pkg::QUO_W-2:0], 1'b0} + pps_pkg::QUO_W'(2);
          end else if (t_c >= den_r) begin
            rem_r <= t_c - den_r;
            q_r   <= {q_r[pps_pkg::QUO_W-2:0], 1'b1};
          end else begin
            rem_r <= t_c;
            q_r   <= {q_r[pps_pkg::QUO_W-2:0], 1'b0};
          end
          dm_r <= {dm_r[pps_pkg::DIFF_W-2:0], 1'b0};
          if (bit_r == '0) begin
            state_r <= S_DFIN;
          end else begin
            bit_r <= bit_r - 1'b1;
          end
        end
        S_DFIN: begin
          case (crd_r)
            2'd0:    spx_r <= coord_c;
            2'd1:    spy_r <= coord_c;
            default: spz_r <= coord_c;
          endcase
          if (crd_r == 2'd2) begin
            state_r <= S_PUTS;
          end else begin
            crd_r   <= crd_r + 1'b1;
            state_r <= S_DSET;
          end
        end
        S_NEXT: begin
          if (at_last_c) begin
            state_r <= S_FLUSH;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RDI;
          end
        end
        S_FLUSH: begin
          if (!pend_v_r || out_free) begin
            pend_v_r <= 1'b0;
            if (!whole_r && !side_r) begin
              side_r  <= 1'b1;
              idx_r   <= '0;
              state_r <= S_RDI;
            end else begin
              cnt_r    <= '0;
              seen_f_r <= 1'b0;
              seen_b_r <= 1'b0;
              drop_r   <= 1'b0;
              state_r  <= S_LOAD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  a_load_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> !pend_v_r)
    else $error("pending word left over while loading");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pps_pkg::CNT_W'(pps_pkg::MAX_VERTS))
    else $error("vertex count beyond buffer depth");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIT) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_split_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUTS && put_ok) |=> (pend_v_r && pend_r.split_point))
    else $error("split point not captured");

endmodule
